// ===== design/pba_pkg.sv =====
// Shared types, constants and helpers for the packed bitfield array.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pba_pkg;

   // Storage geometry.
   localparam int MEM_WORDS = 4096;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int MEM_BITS  = MEM_WORDS * 64;

   // Field and internal widths.
   localparam int WB_W   = 7;   // entry width register
   localparam int OFS_W  = 18;  // offsets and indexes
   localparam int CNT_W  = 19;  // live entry count
   localparam int CSR_W  = 19;  // widest configuration register
   localparam int POS_W  = 20;  // slot position, offset plus count
   localparam int BIT_W  = POS_W + WB_W;  // bit address of a slot

   localparam logic [WB_W-1:0] WB_RESET = WB_W'(32);

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_COMPACT = 2'd2
   } pba_op_type;

   typedef enum logic [1:0] {
      CSR_WORD_BITS       = 2'd0,
      CSR_RESERVED_OFFSET = 2'd1,
      CSR_WORD_COUNT      = 2'd2
   } pba_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_CHECK,
      ST_LO,
      ST_HI,
      ST_DONE
   } pba_state_type;

   // What the current slot access belongs to.
   typedef enum logic [1:0] {
      PH_ACCESS,  // plain read or write
      PH_CSPAN,   // compact: range check of the last source entry
      PH_CSRC,    // compact: read of a source entry
      PH_CDST     // compact: write of a destination entry
   } pba_phase_type;

   // Entry width as used: zero acts as one, anything above 64 as 64.
   function automatic logic [WB_W-1:0] eff_width(input logic [WB_W-1:0] wb);
      logic [WB_W-1:0] r;
      if (wb == '0) begin
         r = WB_W'(1);
      end else if (wb > WB_W'(64)) begin
         r = WB_W'(64);
      end else begin
         r = wb;
      end
      return r;
   endfunction

   // Low wb bits set; wb is 1 to 64.
   function automatic logic [63:0] field_mask(input logic [WB_W-1:0] wb);
      logic [WB_W-1:0] sh;
      sh = WB_W'(64) - wb;
      return {64{1'b1}} >> sh;
   endfunction

endpackage

// ===== design/pba_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on pba_pkg for field widths.
`timescale 1ns / 1ps

interface pba_req_if
   import pba_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [1:0]       opcode;
   logic [OFS_W-1:0] index;
   logic [63:0]      value;
   logic [OFS_W-1:0] new_reserve;

   modport source (output valid, opcode, index, value, new_reserve, input ready);
   modport sink   (input valid, opcode, index, value, new_reserve, output ready);
endinterface

interface pba_rsp_if
   import pba_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [63:0] read_value;
   logic        accepted;

   modport source (output valid, read_value, accepted, input ready);
   modport sink   (input valid, read_value, accepted, output ready);
endinterface

// ===== design/packed_bitfield_array_core.sv =====
// Read and write: an accepted request word passes ST_ADDR, ST_CHECK, ST_LO, ST_HI when the
// entry straddles two memory words, then ST_DONE, which registers the response word once the
// receiver is free; the next request is taken only from the cycle that word is offered.
// Compact: a range check of the last source entry, then per entry a source read and a destination
// write (with ST_HI where one straddles); rejected requests and empty compacts skip the accesses.
// Synchronous active-high reset clears control state and loads the register defaults;
// the storage memory is not cleared and holds undefined data until written.
`timescale 1ns / 1ps

module packed_bitfield_array_core
   import pba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   pba_req_if.sink          req_ch,
   pba_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   // Storage.
   logic [63:0]       mem [MEM_WORDS];
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [63:0]       mem_wdata;
   logic              mem_re;
   logic [MEM_AW-1:0] mem_raddr;
   logic [63:0]       rdata_ff;

   // Configuration and offset.
   logic [WB_W-1:0]   word_bits_ff, word_bits_in;
   logic [CNT_W-1:0]  word_count_ff, word_count_in;
   logic [OFS_W-1:0]  cur_off_ff, cur_off_in;

   // Sequencer.
   pba_state_type     state_ff, state_in;
   pba_phase_type     phase_ff, phase_in;
   logic [1:0]        op_ff, op_in;
   logic [OFS_W-1:0]  nres_ff, nres_in;
   logic [63:0]       val_ff, val_in;
   logic              ok_ff, ok_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_value_ff, rsp_value_in;
   logic              rsp_ok_ff, rsp_ok_in;

   // Datapath helpers.
   logic [WB_W-1:0]   eff_wb;
   logic [63:0]       fmask;
   logic [5:0]        bit_sh;
   logic [WB_W-1:0]   hi_sh;
   logic [MEM_AW-1:0] wnum;
   logic              straddle;
   logic              fits;
   logic              wr_mode;
   logic              req_fire;
   logic              rsp_free;
   logic              cnt_last;
   logic [63:0]       hi_mask;
   logic [63:0]       lo_val, hi_val, lo_word, hi_word;

   assign eff_wb   = eff_width(word_bits_ff);
   assign fmask    = field_mask(eff_wb);
   assign bit_sh   = bit_ff[5:0];
   assign hi_sh    = WB_W'(64) - {1'b0, bit_sh};
   assign wnum     = bit_ff[6 +: MEM_AW];
   assign straddle = ({1'b0, eff_wb} + {2'b0, bit_sh}) > 8'd64;
   assign fits     = ({1'b0, bit_ff} + (BIT_W + 1)'(eff_wb)) <= (BIT_W + 1)'(MEM_BITS);
   assign wr_mode  = (phase_ff == PH_CDST) ||
                     (phase_ff == PH_ACCESS && op_ff == OP_WRITE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign cnt_last = (cnt_ff + CNT_W'(1)) == word_count_ff;

   // Low part lies at bit_sh of the first word, high part at bit 0 of the next.
   assign hi_mask = fmask >> hi_sh;
   assign lo_val  = (rdata_ff >> bit_sh) & fmask;
   assign hi_val  = val_ff | ((rdata_ff & hi_mask) << hi_sh);
   assign lo_word = (rdata_ff & ~(fmask << bit_sh)) | (val_ff << bit_sh);
   assign hi_word = (rdata_ff & ~hi_mask) | (val_ff >> hi_sh);

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.accepted   = rsp_ok_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.opcode)
                  OP_WRITE, OP_READ: state_in = ST_ADDR;
                  OP_COMPACT: begin
                     if (req_ch.new_reserve > cur_off_ff || word_count_ff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_ADDR;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_ADDR: state_in = ST_CHECK;
         ST_CHECK: begin
            unique case (phase_ff)
               PH_ACCESS: state_in = fits ? ST_LO : ST_DONE;
               PH_CSPAN:  state_in = fits ? ST_ADDR : ST_DONE;
               default:   state_in = ST_LO;
            endcase
         end
         ST_LO, ST_HI: begin
            if (state_ff == ST_LO && straddle) begin
               state_in = ST_HI;
            end else begin
               unique case (phase_ff)
                  PH_CDST:  state_in = cnt_last ? ST_DONE : ST_ADDR;
                  PH_CSRC:  state_in = ST_ADDR;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and register updates.
   always_comb begin
      word_bits_in  = word_bits_ff;
      word_count_in = word_count_ff;
      cur_off_in    = cur_off_ff;
      phase_in      = phase_ff;
      op_in         = op_ff;
      nres_in       = nres_ff;
      val_in        = val_ff;
      ok_in         = ok_ff;
      pos_in        = pos_ff;
      bit_in        = bit_ff;
      cnt_in        = cnt_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      mem_we        = 1'b0;
      mem_waddr     = wnum;
      mem_wdata     = lo_word;
      mem_re        = 1'b0;
      mem_raddr     = wnum;

      if (csr_we) begin
         unique case (csr_index)
            CSR_WORD_BITS:       word_bits_in  = csr_wdata[WB_W-1:0];
            CSR_RESERVED_OFFSET: cur_off_in    = csr_wdata[OFS_W-1:0];
            CSR_WORD_COUNT:      word_count_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_ch.opcode;
               nres_in = req_ch.new_reserve;
               val_in  = req_ch.value & fmask;
               ok_in   = 1'b0;
               if (req_ch.opcode == OP_COMPACT) begin
                  phase_in = PH_CSPAN;
                  pos_in   = POS_W'(cur_off_ff) + POS_W'(word_count_ff) - POS_W'(1);
                  if (req_ch.new_reserve <= cur_off_ff && word_count_ff == '0) begin
                     cur_off_in = req_ch.new_reserve;
                     ok_in      = 1'b1;
                  end
               end else begin
                  phase_in = PH_ACCESS;
                  pos_in   = POS_W'(req_ch.index) + POS_W'(cur_off_ff);
               end
            end
         end
         ST_ADDR: begin
            bit_in = BIT_W'(pos_ff) * BIT_W'(eff_wb);
         end
         ST_CHECK: begin
            if (phase_ff == PH_CSPAN) begin
               if (fits) begin
                  phase_in = PH_CSRC;
                  cnt_in   = '0;
                  pos_in   = POS_W'(cur_off_ff);
               end
            end else if (phase_ff != PH_ACCESS || fits) begin
               mem_re = 1'b1;
            end
         end
         ST_LO, ST_HI: begin
            if (state_ff == ST_LO) begin
               if (wr_mode) begin
                  mem_we = 1'b1;
               end else begin
                  val_in = lo_val;
               end
               if (straddle) begin
                  mem_re    = 1'b1;
                  mem_raddr = wnum + MEM_AW'(1);
               end
            end else begin
               if (wr_mode) begin
                  mem_we    = 1'b1;
                  mem_waddr = wnum + MEM_AW'(1);
                  mem_wdata = hi_word;
               end else begin
                  val_in = hi_val;
               end
            end
            // Actions at the end of a slot access.
            if (state_ff == ST_HI || !straddle) begin
               unique case (phase_ff)
                  PH_CSRC: begin
                     phase_in = PH_CDST;
                     pos_in   = POS_W'(nres_ff) + POS_W'(cnt_ff);
                  end
                  PH_CDST: begin
                     if (cnt_last) begin
                        cur_off_in = nres_ff;
                        ok_in      = 1'b1;
                     end else begin
                        phase_in = PH_CSRC;
                        cnt_in   = cnt_ff + CNT_W'(1);
                        pos_in   = POS_W'(cur_off_ff) + POS_W'(cnt_ff) + POS_W'(1);
                     end
                  end
                  default: ok_in = 1'b1;
               endcase
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_value_in = (op_ff == OP_READ && ok_ff) ? val_ff : 64'd0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_ACCESS;
         word_bits_ff  <= WB_RESET;
         word_count_ff <= '0;
         cur_off_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         word_bits_ff  <= word_bits_in;
         word_count_ff <= word_count_in;
         cur_off_ff    <= cur_off_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      nres_ff      <= nres_in;
      val_ff       <= val_in;
      ok_ff        <= ok_in;
      pos_ff       <= pos_in;
      bit_ff       <= bit_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

`ifndef ASSERT_OFF
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("memory written while the sequencer is idle");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("read and write of the same memory word in one cycle");

   a_rsp_zero_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.accepted |-> rsp_ch.read_value == 64'd0)
      else $error("refused word carries a nonzero read value");

   a_offset_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(cur_off_ff) && !$past(csr_we)
         |-> $past(op_ff) == OP_COMPACT || $past(req_ch.opcode) == OP_COMPACT)
      else $error("offset changed outside a compact or register write");
`endif

endmodule

// ===== sim/packed_bitfield_array_core_tb.sv =====
// Self-checking testbench for packed_bitfield_array_core: directed table, then random phases.
// Depends on pba_pkg and the pba_req_if / pba_rsp_if channel interfaces of the design.
`timescale 1ns / 1ps

module packed_bitfield_array_core_tb;
   import pba_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int    STALL_LIMIT      = 5000;
   localparam int    HOLD_CYCLES      = 300;
   localparam int    SETTLE_CYCLES    = 8;
   localparam int    RANDOM_PER_PHASE = 140;
   localparam int    PHASES           = 8;
   localparam bit    TYPED            = 1'b1;
   localparam bit    BY_MODEL         = 1'b0;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [OFS_W-1:0] index;
      logic [63:0]      value;
      logic [OFS_W-1:0] new_reserve;
   } request_t;

   typedef struct packed {
      logic [63:0] read_value;
      logic        accepted;
   } result_t;

   typedef struct packed {
      bit               is_cfg;
      logic [WB_W-1:0]  wb;
      logic [OFS_W-1:0] rsv;
      logic [CNT_W-1:0] cnt;
      request_t         rq;
      bit               typed;
      result_t          want;
   } row_t;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [CSR_W-1:0] csr_wdata;

   pba_req_if req_ch ();
   pba_rsp_if rsp_ch ();

   packed_bitfield_array_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the packed store, one bit per memory bit, plus which bits were ever written.
   bit               shadow_bits  [MEM_BITS];
   bit               shadow_known [MEM_BITS];
   logic [OFS_W-1:0] shadow_ofs;
   logic [WB_W-1:0]  cfg_width;
   logic [CNT_W-1:0] cfg_count;

   result_t    pending_results [$];
   idle_mode_t idle_mode = IDLE_NONE;
   int         mismatches = 0;
   int         hold_asked = 0;
   int         hold_granted = 0;
   int         hold_left = 0;
   int         stall_cycles = 0;

   function automatic int unsigned entry_bits();
      if (cfg_width == '0) return 1;
      if (cfg_width > WB_W'(64)) return 64;
      return int'(cfg_width);
   endfunction

   function automatic bit slot_fits(longint unsigned slot);
      longint unsigned w;
      w = entry_bits();
      return slot * w + w <= longint'(MEM_BITS);
   endfunction

   function automatic logic [63:0] slot_value(longint unsigned slot);
      logic [63:0]     v;
      longint unsigned base;
      int unsigned     w;
      w = entry_bits();
      base = slot * w;
      v = '0;
      for (int unsigned k = 0; k < w; k++) v[k] = shadow_bits[base + k];
      return v;
   endfunction

   function automatic bit slot_written(longint unsigned slot);
      longint unsigned base;
      int unsigned     w;
      bit              all;
      w = entry_bits();
      base = slot * w;
      all = 1'b1;
      for (int unsigned k = 0; k < w; k++) all &= shadow_known[base + k];
      return all;
   endfunction

   function automatic void slot_store(longint unsigned slot, logic [63:0] v);
      longint unsigned base;
      int unsigned     w;
      w = entry_bits();
      base = slot * w;
      for (int unsigned k = 0; k < w; k++) begin
         shadow_bits[base + k] = v[k];
         shadow_known[base + k] = 1'b1;
      end
   endfunction

   // A compact goes ahead only toward a reserve no higher than the current one and with every source slot in range.
   function automatic bit compact_allowed(logic [OFS_W-1:0] nres);
      return nres <= shadow_ofs && (cfg_count == '0 ||
             slot_fits(longint'(shadow_ofs) + longint'(cfg_count) - 1));
   endfunction

   function automatic result_t apply_request(request_t rq);
      result_t         r;
      longint unsigned slot;
      longint unsigned old;
      r = '0;
      slot = longint'(rq.index) + longint'(shadow_ofs);
      case (rq.opcode)
         OP_WRITE: begin
            if (slot_fits(slot)) begin
               slot_store(slot, rq.value);
               r.accepted = 1'b1;
            end
         end
         OP_READ: begin
            if (slot_fits(slot)) begin
               r.read_value = slot_value(slot);
               r.accepted = 1'b1;
            end
         end
         OP_COMPACT: begin
            if (compact_allowed(rq.new_reserve)) begin
               old = shadow_ofs;
               // Ascending order is safe since the destination never lies above the source.
               for (longint unsigned i = 0; i < cfg_count; i++)
                  slot_store(longint'(rq.new_reserve) + i, slot_value(old + i));
               shadow_ofs = rq.new_reserve;
               r.accepted = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic row_t cfg_row(logic [WB_W-1:0] wb, logic [OFS_W-1:0] rsv,
                                    logic [CNT_W-1:0] cnt);
      row_t r;
      r = '0;
      r.is_cfg = 1'b1;
      r.wb = wb;
      r.rsv = rsv;
      r.cnt = cnt;
      return r;
   endfunction

   function automatic row_t op_row(logic [1:0] op, logic [OFS_W-1:0] idx, logic [63:0] val,
                                   logic [OFS_W-1:0] nres, bit typed, logic [63:0] rv,
                                   logic ok);
      row_t r;
      r = '0;
      r.rq.opcode = op;
      r.rq.index = idx;
      r.rq.value = val;
      r.rq.new_reserve = nres;
      r.typed = typed;
      r.want.read_value = rv;
      r.want.accepted = ok;
      return r;
   endfunction

   // Lowers valid, waits for every outstanding response, then lets the block settle.
   task automatic quiesce(int settle);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic load_config(logic [WB_W-1:0] wb, logic [OFS_W-1:0] rsv,
                              logic [CNT_W-1:0] cnt);
      quiesce(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_index <= CSR_WORD_BITS;
      csr_wdata <= CSR_W'(wb);
      @(negedge clock);
      csr_index <= CSR_RESERVED_OFFSET;
      csr_wdata <= CSR_W'(rsv);
      @(negedge clock);
      csr_index <= CSR_WORD_COUNT;
      csr_wdata <= CSR_W'(cnt);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_width  = wb;
      shadow_ofs = rsv;
      cfg_count  = cnt;
   endtask

   task automatic send_request(request_t rq, bit typed, result_t typed_want);
      result_t predicted;
      while ((idle_mode == IDLE_SEND && $urandom_range(99) < 81) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 20)) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= rq.opcode;
      req_ch.index       <= rq.index;
      req_ch.value       <= rq.value;
      req_ch.new_reserve <= rq.new_reserve;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predicted = apply_request(rq);
      pending_results.push_back(typed ? typed_want : predicted);
      @(negedge clock);
   endtask

   task automatic flag_mismatch(string what, result_t want, logic [63:0] got_rv, logic got_ok);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected read_value %h accepted %b, got read_value %h accepted %b",
                  $time, what, want.read_value, want.accepted, got_rv, got_ok);
   endtask

   // Response side: ready follows the idle mode, except during a requested long hold-off.
   always @(negedge clock) begin
      if (hold_left == 0 && hold_asked != hold_granted) begin
         hold_granted++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECV: rsp_ch.ready <= ($urandom_range(99) >= 81);
            IDLE_BOTH: rsp_ch.ready <= ($urandom_range(99) >= 20);
            default:   rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      result_t want;
      if (reset !== 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("response word with nothing pending", '0,
                          rsp_ch.read_value, rsp_ch.accepted);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.read_value !== want.read_value || rsp_ch.accepted !== want.accepted)
               flag_mismatch("response word mismatch", want, rsp_ch.read_value,
                             rsp_ch.accepted);
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      row_t            directed [$];
      request_t        rq;
      logic [WB_W-1:0] phase_widths [PHASES];
      logic [CNT_W-1:0] cnt;
      longint          edge_idx;
      longint unsigned slot;
      int              r;
      bit              unwritten;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_WRITE;
      req_ch.index       = '0;
      req_ch.value       = '0;
      req_ch.new_reserve = '0;
      rsp_ch.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_WORD_BITS;
      csr_wdata          = '0;
      cfg_width          = WB_RESET;
      shadow_ofs         = '0;
      cfg_count          = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Starts from the reset widths; capacity at 32 bits is 8192 entries, at 64 bits 4096.
      directed = '{
         op_row(OP_READ, '1, '0, '0, TYPED, '0, 1'b0),
         op_row(OP_WRITE, '0, '1, '0, TYPED, '0, 1'b1),
         op_row(OP_READ, '0, '0, '0, TYPED, 64'h0000_0000_FFFF_FFFF, 1'b1),
         op_row(OP_WRITE, 18'd8191, 64'h1234_5678_9ABC_DEF0, '0, TYPED, '0, 1'b1),
         op_row(OP_WRITE, 18'd8192, '1, '0, TYPED, '0, 1'b0),
         op_row(OP_READ, 18'd8191, '0, '0, TYPED, 64'h0000_0000_9ABC_DEF0, 1'b1),
         op_row(OP_UNUSED, '1, '1, '1, TYPED, '0, 1'b0),
         cfg_row(7'd64, '0, '0),
         op_row(OP_WRITE, 18'd4095, '1, '0, TYPED, '0, 1'b1),
         op_row(OP_READ, 18'd4095, '0, '0, TYPED, '1, 1'b1),
         op_row(OP_WRITE, 18'd4096, '0, '0, TYPED, '0, 1'b0),
         cfg_row(7'd0, '0, '0),
         op_row(OP_WRITE, '1, 64'd1, '0, TYPED, '0, 1'b1),
         op_row(OP_READ, '1, '0, '0, BY_MODEL, '0, 1'b0),
         cfg_row(7'd127, '0, '0),
         op_row(OP_READ, 18'd4095, '0, '0, BY_MODEL, '0, 1'b0),
         cfg_row(7'd13, '1, '0),
         op_row(OP_WRITE, '0, '1, '0, TYPED, '0, 1'b0),
         op_row(OP_COMPACT, '0, '0, '1, TYPED, '0, 1'b1),
         cfg_row(7'd13, 18'd10, 19'd4),
         op_row(OP_WRITE, 18'd0, '1, '0, BY_MODEL, '0, 1'b0),
         op_row(OP_WRITE, 18'd1, '0, '0, BY_MODEL, '0, 1'b0),
         op_row(OP_WRITE, 18'd2, 64'hAAAA_AAAA_AAAA_AAAA, '0, BY_MODEL, '0, 1'b0),
         op_row(OP_WRITE, 18'd3, 64'h5555_5555_5555_5555, '0, BY_MODEL, '0, 1'b0),
         op_row(OP_COMPACT, '0, '0, 18'd11, TYPED, '0, 1'b0),
         op_row(OP_COMPACT, '0, '0, 18'd3, BY_MODEL, '0, 1'b0),
         op_row(OP_READ, 18'd2, '0, '0, BY_MODEL, '0, 1'b0),
         cfg_row(7'd13, 18'd10, 19'h40000),
         op_row(OP_COMPACT, '0, '0, '0, TYPED, '0, 1'b0),
         op_row(OP_READ, '0, '0, '1, BY_MODEL, '0, 1'b0)
      };

      foreach (directed[i]) begin
         if (directed[i].is_cfg) begin
            load_config(directed[i].wb, directed[i].rsv, directed[i].cnt);
         end else begin
            send_request(directed[i].rq, directed[i].typed, directed[i].want);
         end
      end

      phase_widths = '{7'd1, 7'd64, 7'd13, 7'd0, 7'd127, 7'd33, 7'd63,
                       WB_W'($urandom_range(2, 63))};

      for (int p = 0; p < PHASES; p++) begin
         idle_mode = idle_mode_t'(p % 4);
         if (p == 3) begin
            cnt = '0;
         end else if (p == 2) begin
            cnt = 19'd1;
         end else begin
            cnt = CNT_W'($urandom_range(2, 40));
         end
         load_config(phase_widths[p], OFS_W'($urandom_range(20, 150)), cnt);

         // Fill the live entries first so that reads and compacts find written data.
         for (int i = 0; i < int'(cfg_count); i++) begin
            rq.opcode      = OP_WRITE;
            rq.index       = OFS_W'(i);
            rq.value       = {$urandom, $urandom};
            rq.new_reserve = OFS_W'($urandom);
            send_request(rq, BY_MODEL, '0);
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == 50 && idle_mode == IDLE_NONE) hold_asked++;
            if (n == 60 && idle_mode == IDLE_SEND) quiesce(0);

            r = $urandom_range(99);
            rq.opcode = (r < 40) ? OP_WRITE : (r < 75) ? OP_READ :
                        (r < 93) ? OP_COMPACT : OP_UNUSED;
            r = $urandom_range(99);
            if (r < 60) begin
               rq.index = OFS_W'($urandom_range(0, int'(cfg_count) + 6));
            end else if (r < 80) begin
               // Around the last entry that still fits in the memory.
               edge_idx = longint'(MEM_BITS / entry_bits()) - longint'(shadow_ofs)
                          + longint'($urandom_range(0, 5)) - 3;
               rq.index = OFS_W'(edge_idx);
            end else begin
               rq.index = OFS_W'($urandom);
            end
            r = $urandom_range(99);
            rq.value = (r < 15) ? '1 : (r < 25) ? '0 : {$urandom, $urandom};
            r = $urandom_range(99);
            if (r < 70 && shadow_ofs != '0) begin
               rq.new_reserve = shadow_ofs -
                  OFS_W'($urandom_range(0, (shadow_ofs < 4) ? int'(shadow_ofs) : 4));
            end else if (r < 85) begin
               rq.new_reserve = OFS_W'($urandom_range(0, int'(shadow_ofs)));
            end else begin
               rq.new_reserve = OFS_W'($urandom);
            end

            // Never read storage that was not written; such a word becomes a write instead.
            unwritten = 1'b0;
            slot = longint'(rq.index) + longint'(shadow_ofs);
            if (rq.opcode == OP_READ) begin
               unwritten = slot_fits(slot) && !slot_written(slot);
            end else if (rq.opcode == OP_COMPACT && compact_allowed(rq.new_reserve)) begin
               for (longint unsigned i = 0; i < cfg_count; i++)
                  if (!slot_written(longint'(shadow_ofs) + i)) unwritten = 1'b1;
            end
            if (unwritten) rq.opcode = OP_WRITE;

            send_request(rq, BY_MODEL, '0);
         end
      end

      quiesce(20);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
